@@ rtl/core/sfla_pkg.sv @@
// Package with shared constants, codes and controller/datapath interface types.
`default_nettype none
package sfla_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int ID_W      = $clog2(MAX_SLOTS);
    localparam int CNT_W     = ID_W + 1;
    localparam int LINK_W    = 32;
    localparam int SLOT_ID_W = 10;
    localparam int ADDR_W    = 64;
    localparam int SB_W      = 16;
    localparam int SIU_W     = 11;
    localparam int PROD_W    = ID_W + SB_W;
    localparam int REQ_W     = 2;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 64;

    localparam logic [LINK_W-1:0] END_MARK = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_INIT  = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_FREE  = 2'd2,
        REQ_FIND  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOMEM   = 3'd1,
        ST_RANGE   = 3'd2,
        ST_CORRUPT = 3'd3,
        ST_CYCLE   = 3'd4,
        ST_NONE    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        REG_BASE_ADDR    = 2'd0,
        REG_SLOT_BYTES   = 2'd1,
        REG_SLOTS_IN_USE = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CHAIN,
        OP_ALLOC_GO,
        OP_POP,
        OP_FREE,
        OP_VCLR,
        OP_WALK_RD,
        OP_WALK_STEP,
        OP_SCAN_RD,
        OP_SCAN_HIT,
        OP_IDX_INC,
        OP_MUL,
        OP_RES_ADDR,
        OP_RES_ZERO
    } t_dp_op;

    typedef enum logic [3:0] {
        S_RST_FILL,
        S_IDLE,
        S_INIT,
        S_INIT_RES,
        S_ALLOC_CHK,
        S_ALLOC_POP,
        S_MUL,
        S_ADD,
        S_FREE,
        S_VCLR,
        S_WALK_ISSUE,
        S_WALK_CHK,
        S_SCAN_RD,
        S_SCAN_CHK
    } t_state;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
        logic    full;
        logic    accept;
    } t_cmd;

    typedef struct packed {
        logic head_end;
        logic head_oor;
        logic link_corrupt;
        logic cur_stop;
        logic idx_last;
        logic vis_set;
    } t_sts;

endpackage
`default_nettype wire

@@ rtl/core/slab_free_list_allocator_top.sv @@
// Top level of the slab free-list allocator with its configuration registers.
//
//   Port group        Direction  Handshake
//   request           in         start / busy, beat taken when start high and busy low
//   result            out        o_done strobe, one cycle, always taken
//   configuration     in/out     psel / penable / pwrite / pready, 64-bit data
//
// A free makes the freed slot the new head; an alloc checks the head, pops it, multiplies
// and adds, ending early on no_memory or out_of_range at the check or corrupt_link at the
// pop. An init chains the slot count, where the slot count is slots_in_use held to 1..1024.
// A find clears the visited map, walks the list, scans, and multiplies and adds after a hit.
// After reset the link memory is chained over all 1024 slots with busy high.
// Results are strobed for one cycle and cannot be stalled.
`default_nettype none
module slab_free_list_allocator_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [sfla_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic [sfla_pkg::LINK_W-1:0]   i_free_id,
    output logic                               o_done,
    output logic [2:0]                         o_status,
    output logic [sfla_pkg::SLOT_ID_W-1:0]     o_slot_id,
    output logic [sfla_pkg::ADDR_W-1:0]        o_slot_addr,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sfla_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [sfla_pkg::PDATA_W-1:0]  pwdata,
    output logic [sfla_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import sfla_pkg::*;

    logic [ADDR_W-1:0] r_base_addr;
    logic [SB_W-1:0]   r_slot_bytes;
    logic [SIU_W-1:0]  r_slots_in_use;
    logic              wr_beat;
    t_reg_idx          reg_idx;
    t_cmd              cmd;
    t_sts              sts;

    assign pready  = 1'b1;
    assign wr_beat = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr    <= '0;
            r_slot_bytes   <= SB_W'(64);
            r_slots_in_use <= SIU_W'(MAX_SLOTS);
        end else if (wr_beat) begin
            case (reg_idx)
                REG_BASE_ADDR:    r_base_addr    <= pwdata;
                REG_SLOT_BYTES:   r_slot_bytes   <= pwdata[SB_W-1:0];
                REG_SLOTS_IN_USE: r_slots_in_use <= pwdata[SIU_W-1:0];
                default:          r_base_addr    <= r_base_addr;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BASE_ADDR:    prdata = r_base_addr;
            REG_SLOT_BYTES:   prdata = PDATA_W'(r_slot_bytes);
            REG_SLOTS_IN_USE: prdata = PDATA_W'(r_slots_in_use);
            default:          prdata = '0;
        endcase
    end

    sfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    sfla_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_free_id      (i_free_id),
        .i_base_addr    (r_base_addr),
        .i_slot_bytes   (r_slot_bytes),
        .i_slots_in_use (r_slots_in_use),
        .o_sts          (sts),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_slot_id      (o_slot_id),
        .o_slot_addr    (o_slot_addr)
    );

endmodule
`default_nettype wire

@@ rtl/core/sfla_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sfla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/sfla_ctrl.sv @@
// Controller state machine that sequences requests through the datapath.
`default_nettype none
module sfla_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [sfla_pkg::REQ_W-1:0] i_req_type,
    input  wire sfla_pkg::t_sts             i_sts,
    output sfla_pkg::t_cmd                  o_cmd,
    output logic                            o_busy
);
    import sfla_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RST_FILL: begin
                if (i_sts.idx_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    case (t_req'(i_req_type))
                        REQ_INIT:  n_state = S_INIT;
                        REQ_ALLOC: n_state = S_ALLOC_CHK;
                        REQ_FREE:  n_state = S_FREE;
                        REQ_FIND:  n_state = S_VCLR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_INIT: begin
                if (i_sts.idx_last) n_state = S_INIT_RES;
            end
            S_INIT_RES: n_state = S_IDLE;
            S_ALLOC_CHK: begin
                if (i_sts.head_end || i_sts.head_oor) n_state = S_IDLE;
                else n_state = S_ALLOC_POP;
            end
            S_ALLOC_POP: begin
                if (i_sts.link_corrupt) n_state = S_IDLE;
                else n_state = S_MUL;
            end
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = S_IDLE;
            S_FREE: n_state = S_IDLE;
            S_VCLR: begin
                if (i_sts.idx_last) n_state = S_WALK_ISSUE;
            end
            S_WALK_ISSUE: begin
                if (i_sts.cur_stop) n_state = S_SCAN_RD;
                else n_state = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (i_sts.vis_set) n_state = S_IDLE;
                else n_state = S_WALK_ISSUE;
            end
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (!i_sts.vis_set) n_state = S_MUL;
                else if (i_sts.idx_last) n_state = S_IDLE;
                else n_state = S_SCAN_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = OP_NONE;
        o_cmd.status = ST_OK;
        o_busy       = 1'b1;
        case (r_state)
            S_RST_FILL: begin
                o_cmd.op   = OP_CHAIN;
                o_cmd.full = 1'b1;
            end
            S_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            S_INIT: o_cmd.op = OP_CHAIN;
            S_INIT_RES: o_cmd.op = OP_RES_ZERO;
            S_ALLOC_CHK: begin
                if (i_sts.head_end) begin
                    o_cmd.op     = OP_RES_ZERO;
                    o_cmd.status = ST_NOMEM;
                end else if (i_sts.head_oor) begin
                    o_cmd.op     = OP_RES_ZERO;
                    o_cmd.status = ST_RANGE;
                end else begin
                    o_cmd.op = OP_ALLOC_GO;
                end
            end
            S_ALLOC_POP: o_cmd.op = OP_POP;
            S_MUL: o_cmd.op = OP_MUL;
            S_ADD: o_cmd.op = OP_RES_ADDR;
            S_FREE: o_cmd.op = OP_FREE;
            S_VCLR: o_cmd.op = OP_VCLR;
            S_WALK_ISSUE: begin
                if (!i_sts.cur_stop) o_cmd.op = OP_WALK_RD;
            end
            S_WALK_CHK: begin
                if (i_sts.vis_set) begin
                    o_cmd.op     = OP_RES_ZERO;
                    o_cmd.status = ST_CYCLE;
                end else begin
                    o_cmd.op = OP_WALK_STEP;
                end
            end
            S_SCAN_RD: o_cmd.op = OP_SCAN_RD;
            S_SCAN_CHK: begin
                if (!i_sts.vis_set) begin
                    o_cmd.op = OP_SCAN_HIT;
                end else if (i_sts.idx_last) begin
                    o_cmd.op     = OP_RES_ZERO;
                    o_cmd.status = ST_NONE;
                end else begin
                    o_cmd.op = OP_IDX_INC;
                end
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/sfla_dp.sv @@
// Datapath with the link and visited memories, list head, walk registers and address unit.
`default_nettype none
module sfla_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire sfla_pkg::t_cmd                 i_cmd,
    input  wire logic [sfla_pkg::LINK_W-1:0]    i_free_id,
    input  wire logic [sfla_pkg::ADDR_W-1:0]    i_base_addr,
    input  wire logic [sfla_pkg::SB_W-1:0]      i_slot_bytes,
    input  wire logic [sfla_pkg::SIU_W-1:0]     i_slots_in_use,
    output sfla_pkg::t_sts                      o_sts,
    output logic                                o_done,
    output logic [2:0]                          o_status,
    output logic [sfla_pkg::SLOT_ID_W-1:0]      o_slot_id,
    output logic [sfla_pkg::ADDR_W-1:0]         o_slot_addr
);
    import sfla_pkg::*;

    logic [CNT_W-1:0]  total;
    logic [LINK_W-1:0] total_w;
    logic [CNT_W-1:0]  r_idx;
    logic [LINK_W-1:0] r_head;
    logic [LINK_W-1:0] r_cur;
    logic [LINK_W-1:0] r_fid;
    logic [PROD_W-1:0] r_prod;
    logic              r_done;
    t_status           r_status;
    logic [SLOT_ID_W-1:0] r_slot_id;
    logic [ADDR_W-1:0] r_slot_addr;

    logic              idx_last;
    logic              fid_in_range;
    logic              link_corrupt;
    logic              link_wr_en;
    logic [ID_W-1:0]   link_wr_addr;
    logic [LINK_W-1:0] link_wr_data;
    logic              link_rd_en;
    logic [ID_W-1:0]   link_rd_addr;
    logic [LINK_W-1:0] link_rd_data;
    logic              vis_wr_en;
    logic [ID_W-1:0]   vis_wr_addr;
    logic              vis_rd_en;
    logic [ID_W-1:0]   vis_rd_addr;
    logic              vis_rd_data;

    always_comb begin
        if (i_cmd.full) begin
            total = CNT_W'(MAX_SLOTS);
        end else if (i_slots_in_use == '0) begin
            total = CNT_W'(1);
        end else if (32'(i_slots_in_use) > 32'(MAX_SLOTS)) begin
            total = CNT_W'(MAX_SLOTS);
        end else begin
            total = CNT_W'(i_slots_in_use);
        end
    end

    assign total_w      = LINK_W'(total);
    assign idx_last     = (r_idx == total - CNT_W'(1));
    assign fid_in_range = (r_fid < total_w);
    assign link_corrupt = (link_rd_data >= total_w) && (link_rd_data != END_MARK);

    assign o_sts.head_end     = (r_head == END_MARK);
    assign o_sts.head_oor     = (r_head >= total_w);
    assign o_sts.link_corrupt = link_corrupt;
    assign o_sts.cur_stop     = (r_cur >= total_w);
    assign o_sts.idx_last     = idx_last;
    assign o_sts.vis_set      = vis_rd_data;

    assign link_wr_en   = (i_cmd.op == OP_CHAIN) || ((i_cmd.op == OP_FREE) && fid_in_range);
    assign link_wr_addr = (i_cmd.op == OP_CHAIN) ? r_idx[ID_W-1:0] : r_fid[ID_W-1:0];
    assign link_wr_data = (i_cmd.op != OP_CHAIN) ? r_head :
                          idx_last ? END_MARK : (LINK_W'(r_idx) + LINK_W'(1));
    assign link_rd_en   = (i_cmd.op == OP_ALLOC_GO) || (i_cmd.op == OP_WALK_RD);
    assign link_rd_addr = (i_cmd.op == OP_ALLOC_GO) ? r_head[ID_W-1:0] : r_cur[ID_W-1:0];

    assign vis_wr_en   = (i_cmd.op == OP_VCLR) || (i_cmd.op == OP_WALK_STEP);
    assign vis_wr_addr = (i_cmd.op == OP_VCLR) ? r_idx[ID_W-1:0] : r_cur[ID_W-1:0];
    assign vis_rd_en   = (i_cmd.op == OP_WALK_RD) || (i_cmd.op == OP_SCAN_RD);
    assign vis_rd_addr = (i_cmd.op == OP_WALK_RD) ? r_cur[ID_W-1:0] : r_idx[ID_W-1:0];

    sfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_SLOTS)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_wr_en),
        .i_wr_addr (link_wr_addr),
        .i_wr_data (link_wr_data),
        .i_rd_en   (link_rd_en),
        .i_rd_addr (link_rd_addr),
        .o_rd_data (link_rd_data)
    );

    sfla_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SLOTS)
    ) u_vis_ram (
        .i_clk     (i_clk),
        .i_wr_en   (vis_wr_en),
        .i_wr_addr (vis_wr_addr),
        .i_wr_data (i_cmd.op == OP_WALK_STEP),
        .i_rd_en   (vis_rd_en),
        .i_rd_addr (vis_rd_addr),
        .o_rd_data (vis_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_head <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.accept) begin
                r_idx <= '0;
            end
            case (i_cmd.op)
                OP_CHAIN: begin
                    if (idx_last) begin
                        r_idx  <= '0;
                        r_head <= '0;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                OP_POP: begin
                    r_head <= link_rd_data;
                    if (link_corrupt) r_done <= 1'b1;
                end
                OP_FREE: begin
                    r_head <= r_fid;
                    r_done <= 1'b1;
                end
                OP_VCLR: begin
                    if (idx_last) r_idx <= '0;
                    else r_idx <= r_idx + CNT_W'(1);
                end
                OP_IDX_INC: r_idx <= r_idx + CNT_W'(1);
                OP_RES_ADDR: r_done <= 1'b1;
                OP_RES_ZERO: r_done <= 1'b1;
                default: r_done <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_fid <= i_free_id;
        end
        case (i_cmd.op)
            OP_ALLOC_GO: r_cur <= r_head;
            OP_POP: begin
                r_status    <= ST_CORRUPT;
                r_slot_id   <= '0;
                r_slot_addr <= '0;
            end
            OP_FREE: begin
                r_status    <= ST_OK;
                r_slot_id   <= '0;
                r_slot_addr <= '0;
            end
            OP_VCLR: begin
                if (idx_last) r_cur <= r_head;
            end
            OP_WALK_STEP: r_cur <= link_rd_data;
            OP_SCAN_HIT: r_cur <= LINK_W'(r_idx);
            OP_MUL: r_prod <= PROD_W'(r_cur[ID_W-1:0]) * PROD_W'(i_slot_bytes);
            OP_RES_ADDR: begin
                r_status    <= ST_OK;
                r_slot_id   <= SLOT_ID_W'(r_cur);
                r_slot_addr <= i_base_addr + ADDR_W'(r_prod);
            end
            OP_RES_ZERO: begin
                r_status    <= i_cmd.status;
                r_slot_id   <= '0;
                r_slot_addr <= '0;
            end
            default: r_prod <= r_prod;
        endcase
    end

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_slot_id   = r_slot_id;
    assign o_slot_addr = r_slot_addr;

endmodule
`default_nettype wire
